FILE: hdl/rgdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rgdd_pkg;
  localparam int GROUP_MAX_DEF = 16;
  localparam int POOL_ENTRIES_DEF = 1024;
  localparam int REC_W = 72;
  localparam logic [4:0] GROUP_LEN_RESET = 5'd16;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_NEW = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic KIND_INDEX = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_STORE,
    S_RESULT,
    S_EXP_LEN,
    S_EXP_RD,
    S_EXP_OUT,
    S_OUT_WAIT
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/rgdd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rgdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/record_group_dedup_dictionary.sv
`timescale 1ns / 1ps
`default_nettype none
// Record group deduplication dictionary. Records (9 bytes) are pushed one per
// word and gathered into groups of group_len. A push word with tlast set closes
// a short group, and tuser set marks an expand request instead of a push. A
// closing push searches the dictionary in insertion order, comparing records
// only with stored entries of equal length; on a miss the group is stored one
// record per cycle unless the pool is full. The pool memory has one read port
// with a registered read. A push that does not close a group returns to idle
// after a length check. An expand emits one word per record of the group it
// names, or one unknown-status word for an index past the pool. One result is
// held on m_axis until taken, and s_axis_tready is low while a word is at work.
module record_group_dedup_dictionary #(
  parameter int GROUP_MAX = rgdd_pkg::GROUP_MAX_DEF,
  parameter int POOL_ENTRIES = rgdd_pkg::POOL_ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [4:0]  cfg_wdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // record_head, record_tail, expand_index, pad
  input  wire  [87:0] s_axis_tdata,
  // req_type
  input  wire         s_axis_tuser,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status, group_index, out_head, out_tail, total_groups, repeat_groups, pad
  output logic [151:0] m_axis_tdata,
  // kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  localparam int GW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam int CW = $clog2(GROUP_MAX + 1);
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int UW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = PW + GW;
  localparam int RW = rgdd_pkg::REC_W;

  rgdd_pkg::state_t state, state_next;

  logic [4:0]    group_len;
  logic [CW-1:0] gather_count;
  logic [RW-1:0] gather [GROUP_MAX];
  logic [UW-1:0] pool_used;
  logic [31:0]   lookup_count, hit_count;
  logic [PW-1:0] entry;
  logic [CW-1:0] rec;
  logic [CW-1:0] exp_len;
  logic          req_expand, req_eos;
  logic [9:0]    req_index;

  logic          o_kind;
  logic [1:0]    o_status;
  logic [9:0]    o_index;
  logic [RW-1:0] o_rec;
  logic          o_last;

  logic          pool_we, len_we;
  logic [AW-1:0] pool_waddr, pool_raddr;
  logic [RW-1:0] pool_rdata;
  logic [CW-1:0] len_rdata;

  logic [CW-1:0] eff_len;
  logic [GW-1:0] rec_idx;

  always_comb begin
    if (group_len == 5'd0) begin
      eff_len = CW'(1);
    end else if (32'(group_len) > GROUP_MAX) begin
      eff_len = CW'(GROUP_MAX);
    end else begin
      eff_len = CW'(group_len);
    end
  end

  assign rec_idx = rec[GW-1:0];

  rgdd_ram #(.WIDTH(RW), .DEPTH(POOL_ENTRIES * (1 << GW))) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(gather[rec_idx]),
    .raddr(pool_raddr), .rdata(pool_rdata)
  );

  rgdd_ram #(.WIDTH(CW), .DEPTH(POOL_ENTRIES)) u_len (
    .clk(clk), .we(len_we), .waddr(pool_used[PW-1:0]), .wdata(gather_count),
    .raddr(entry), .rdata(len_rdata)
  );

  assign pool_waddr = {pool_used[PW-1:0], rec_idx};
  assign pool_raddr = {entry, rec_idx};

  logic cmp_eq, rec_done, entry_last, exp_last;
  assign cmp_eq = (pool_rdata == gather[rec_idx]);
  assign rec_done = (rec + CW'(1) == gather_count);
  assign entry_last = (UW'(entry) + UW'(1) == pool_used);
  assign exp_last = (rec + CW'(1) == exp_len);

  always_comb begin
    state_next = state;
    case (state)
      rgdd_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            state_next = rgdd_pkg::S_EXP_LEN;
          end else begin
            state_next = rgdd_pkg::S_LEN_RD;
          end
        end
      end
      rgdd_pkg::S_LEN_RD: begin
        if (gather_count < eff_len && !req_eos) begin
          state_next = rgdd_pkg::S_IDLE;
        end else if (pool_used == '0) begin
          state_next = rgdd_pkg::S_STORE;
        end else begin
          state_next = rgdd_pkg::S_LEN_CHK;
        end
      end
      rgdd_pkg::S_LEN_CHK: begin
        if (len_rdata == gather_count) begin
          state_next = rgdd_pkg::S_CMP_CHK;
        end else if (entry_last) begin
          state_next = rgdd_pkg::S_STORE;
        end else begin
          state_next = rgdd_pkg::S_CMP_RD;
        end
      end
      rgdd_pkg::S_CMP_RD: begin
        state_next = rgdd_pkg::S_LEN_CHK;
      end
      rgdd_pkg::S_CMP_CHK: begin
        if (!cmp_eq) begin
          state_next = entry_last ? rgdd_pkg::S_STORE : rgdd_pkg::S_CMP_RD;
        end else if (rec_done) begin
          state_next = rgdd_pkg::S_RESULT;
        end else begin
          state_next = rgdd_pkg::S_CMP_RD;
        end
      end
      rgdd_pkg::S_STORE: begin
        if (pool_used == UW'(POOL_ENTRIES) || rec_done) begin
          state_next = rgdd_pkg::S_RESULT;
        end
      end
      rgdd_pkg::S_RESULT: state_next = rgdd_pkg::S_OUT_WAIT;
      rgdd_pkg::S_EXP_LEN: begin
        if (32'(req_index) >= 32'(pool_used)) begin
          state_next = rgdd_pkg::S_RESULT;
        end else begin
          state_next = rgdd_pkg::S_EXP_RD;
        end
      end
      rgdd_pkg::S_EXP_RD: state_next = rgdd_pkg::S_EXP_OUT;
      rgdd_pkg::S_EXP_OUT: begin
        if (m_axis_tready) begin
          state_next = exp_last ? rgdd_pkg::S_IDLE : rgdd_pkg::S_EXP_RD;
        end
      end
      rgdd_pkg::S_OUT_WAIT: begin
        if (m_axis_tready) begin
          state_next = rgdd_pkg::S_IDLE;
        end
      end
      default: state_next = rgdd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == rgdd_pkg::S_IDLE);
    m_axis_tvalid = (state == rgdd_pkg::S_OUT_WAIT) || (state == rgdd_pkg::S_EXP_OUT);
    pool_we = (state == rgdd_pkg::S_STORE) && (pool_used != UW'(POOL_ENTRIES));
    len_we = pool_we && rec_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgdd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_len <= rgdd_pkg::GROUP_LEN_RESET;
    end else if (cfg_we) begin
      group_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gather_count <= '0;
      pool_used <= '0;
      lookup_count <= '0;
      hit_count <= '0;
    end else begin
      case (state)
        rgdd_pkg::S_IDLE: begin
          if (s_axis_tvalid && !s_axis_tuser && 32'(gather_count) < GROUP_MAX) begin
            gather_count <= gather_count + CW'(1);
          end
        end
        rgdd_pkg::S_LEN_RD: begin
          if (!(gather_count < eff_len && !req_eos) && lookup_count != '1) begin
            lookup_count <= lookup_count + 32'd1;
          end
        end
        rgdd_pkg::S_CMP_CHK: begin
          if (cmp_eq && rec_done && hit_count != '1) begin
            hit_count <= hit_count + 32'd1;
          end
        end
        rgdd_pkg::S_RESULT: begin
          if (!req_expand) begin
            gather_count <= '0;
          end
        end
        rgdd_pkg::S_STORE: begin
          if (len_we) begin
            pool_used <= pool_used + UW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rgdd_pkg::S_IDLE: begin
        req_expand <= s_axis_tuser;
        req_eos <= s_axis_tlast;
        req_index <= s_axis_tdata[81:72];
        if (s_axis_tuser) begin
          entry <= PW'(s_axis_tdata[81:72]);
        end else begin
          entry <= '0;
        end
        rec <= '0;
        if (s_axis_tvalid && !s_axis_tuser && 32'(gather_count) < GROUP_MAX) begin
          gather[gather_count[GW-1:0]] <= s_axis_tdata[71:0];
        end
      end
      rgdd_pkg::S_LEN_RD: rec <= '0;
      rgdd_pkg::S_LEN_CHK: begin
        if (len_rdata != gather_count) begin
          entry <= entry + PW'(1);
        end
      end
      rgdd_pkg::S_CMP_CHK: begin
        if (!cmp_eq) begin
          entry <= entry + PW'(1);
          rec <= '0;
        end else if (rec_done) begin
          o_kind <= rgdd_pkg::KIND_INDEX;
          o_status <= rgdd_pkg::ST_HIT;
          o_index <= 10'(entry);
          o_rec <= '0;
          o_last <= 1'b1;
        end else begin
          rec <= rec + CW'(1);
        end
      end
      rgdd_pkg::S_STORE: begin
        rec <= rec + CW'(1);
        o_kind <= rgdd_pkg::KIND_INDEX;
        o_rec <= '0;
        o_last <= 1'b1;
        if (pool_used == UW'(POOL_ENTRIES)) begin
          o_status <= rgdd_pkg::ST_FULL;
          o_index <= '0;
        end else begin
          o_status <= rgdd_pkg::ST_NEW;
          o_index <= 10'(pool_used);
        end
      end
      rgdd_pkg::S_EXP_LEN: begin
        o_kind <= rgdd_pkg::KIND_RECORD;
        o_status <= rgdd_pkg::ST_UNKNOWN;
        o_index <= '0;
        o_rec <= '0;
        o_last <= 1'b1;
      end
      rgdd_pkg::S_EXP_RD: begin
        exp_len <= len_rdata;
      end
      rgdd_pkg::S_EXP_OUT: begin
        if (m_axis_tready) begin
          rec <= rec + CW'(1);
        end
      end
      default: ;
    endcase
  end

  logic [CW-1:0] exp_n;
  logic          exp_active;
  assign exp_active = (state == rgdd_pkg::S_EXP_OUT);
  assign exp_n = (state == rgdd_pkg::S_EXP_OUT) ? exp_len : gather_count;

  assign m_axis_tlast = exp_active ? exp_last : o_last;
  assign m_axis_tuser = exp_active ? rgdd_pkg::KIND_RECORD : o_kind;
  assign m_axis_tdata = {
    4'd0, hit_count, lookup_count,
    exp_active ? pool_rdata : o_rec,
    exp_active ? req_index : o_index,
    exp_active ? rgdd_pkg::ST_HIT : o_status
  };

  always_ff @(posedge clk) begin
    if (!rst && state == rgdd_pkg::S_STORE && exp_n > CW'(GROUP_MAX)) begin
      $error("gather count above group max");
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != rgdd_pkg::S_IDLE) |-> !s_axis_tready)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    len_we |=> (pool_used != '0))
    else $error("store did not count");
  assert property (@(posedge clk) disable iff (rst)
    (pool_used <= UW'(POOL_ENTRIES)))
    else $error("pool overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (hit_count <= lookup_count))
    else $error("hits exceed lookups");
endmodule
`default_nettype wire
